[hdl/cascaded_echo_delay_core_defines.svh]
// Assertion macros shared by the echo delay checker.
`ifndef CASCADED_ECHO_DELAY_CORE_DEFINES_SVH
`define CASCADED_ECHO_DELAY_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CEDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CEDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cedc_pkg.sv]
// Types and constants for the cascaded echo delay core.
package cedc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SETTING_W  = 8;
	localparam int CFG_IDX_W  = 1;

	// delay length = BASE_LEN + LEN_STEP * delay_setting
	localparam int BASE_LEN   = 5000;
	localparam int LEN_STEP   = 74;
	localparam int LEN_RAW_W  = 17;

	// gain and mixing shifts
	localparam int GAIN_SHIFT = 7;
	localparam int GAIN_W     = SETTING_W + GAIN_SHIFT;
	localparam int Q_SHIFT    = 15;
	localparam int MIX_SHIFT  = 2;
	localparam int PROD_W     = 2 * SAMPLE_W;
	localparam int SUM_W      = SAMPLE_W + 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 1'b1;

	// register reset values
	localparam logic [SETTING_W-1:0] GAIN_RST  = 8'd234;
	localparam logic [SETTING_W-1:0] DELAY_RST = 8'd243;

	typedef logic signed [SAMPLE_W-1:0]  sample_t;
	typedef logic        [SETTING_W-1:0] setting_t;
	typedef logic signed [PROD_W-1:0]    prod_t;

endpackage

[hdl/cascaded_echo_delay_core.sv]
// Cascaded three-tap echo delay: ring memories, tap scaling and output mix.
//
// Usage:
//   Input channel in_valid/in_ready carries sample_in, one signed 16-bit
//   sample per item; output channel out_valid/out_ready returns sample_out,
//   one mixed sample per item, in order.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 gain_setting, 1 delay_setting); write only while the core is idle.
//   Path: an accepted item passes the stage 1, stage 2 and output registers
//   in order. Throughput: one item per cycle while not stalled; each memory
//   has one read port (address stage) and one write port (mix stage), so each
//   item reads and writes one entry of each memory.
//   Stall: the whole pipeline, memory reads included, holds while the output
//   register is full and out_ready is low; in_ready is low in those cycles.
//   Reset: gain 234, delay 243, ring position zero. The memories are not
//   swept; a fill count marks the written prefix of the ring and entries
//   beyond it read as zero, so the core accepts items straight after reset.
//   A ring entry is revisited at least 5000 items after it was last used,
//   far beyond the pipeline depth, so no forwarding is needed.
module cascaded_echo_delay_core #(
	parameter int MAX_DELAY = 24000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cedc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cedc_pkg::SETTING_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  cedc_pkg::sample_t                   sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output cedc_pkg::sample_t                   sample_out
);
	import cedc_pkg::*;

	localparam int POS_W = $clog2(MAX_DELAY);
	localparam int CNT_W = $clog2(MAX_DELAY + 1);

	// configuration registers
	setting_t gain_q;
	setting_t delay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data;
				REG_DELAY: delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Q15 gain and saturated ring length
	logic [GAIN_W-1:0]    gain_q15;
	logic [LEN_RAW_W-1:0] len_raw;
	logic [CNT_W-1:0]     len_sat;

	assign gain_q15 = {gain_q, {GAIN_SHIFT{1'b0}}};
	assign len_raw  = LEN_RAW_W'(BASE_LEN) + LEN_RAW_W'(LEN_STEP) * LEN_RAW_W'(delay_q);
	assign len_sat  = (len_raw > LEN_RAW_W'(MAX_DELAY)) ? CNT_W'(MAX_DELAY)
	                                                    : len_raw[CNT_W-1:0];

	// pipeline advance: the output register is free or being emptied
	logic adv;
	logic accept;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	// ring position and fill count
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] pos_inc;
	logic             unwritten;

	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign unwritten = CNT_W'(pos_q) >= fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			pos_q <= (pos_inc < len_sat) ? pos_inc[POS_W-1:0] : '0;
			if (CNT_W'(pos_q) == fill_q)
				fill_q <= pos_inc;
		end
	end

	// delay memories
	sample_t mem_direct [MAX_DELAY];
	sample_t mem_second [MAX_DELAY];
	sample_t mem_third  [MAX_DELAY];

	sample_t rd_direct_s1;
	sample_t rd_second_s1;
	sample_t rd_third_s1;

	// read port, held while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_direct_s1 <= mem_direct[pos_q];
			rd_second_s1 <= mem_second[pos_q];
			rd_third_s1  <= mem_third[pos_q];
		end
	end

	// stage 1 control and payload
	logic             v_s1;
	logic             zero_s1;
	sample_t          x_s1;
	logic [POS_W-1:0] pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zero_s1 <= unwritten;
			x_s1    <= sample_in;
			pos_s1  <= pos_q;
		end
	end

	// stage 1: mask unwritten entries and scale by the gain
	sample_t w_direct;
	sample_t w_second;
	sample_t w_third;
	sample_t gain_s;

	assign w_direct = zero_s1 ? '0 : rd_direct_s1;
	assign w_second = zero_s1 ? '0 : rd_second_s1;
	assign w_third  = zero_s1 ? '0 : rd_third_s1;
	assign gain_s   = sample_t'({1'b0, gain_q15});

	logic             v_s2;
	sample_t          x_s2;
	logic [POS_W-1:0] pos_s2;
	prod_t            p_direct_s2;
	prod_t            p_second_s2;
	prod_t            p_third_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			x_s2        <= x_s1;
			pos_s2      <= pos_s1;
			p_direct_s2 <= w_direct * gain_s;
			p_second_s2 <= w_second * gain_s;
			p_third_s2  <= w_third * gain_s;
		end
	end

	// stage 2: Q15 taps and four-way mix
	sample_t                  tap1;
	sample_t                  tap2;
	sample_t                  tap3;
	logic signed [SUM_W-1:0]  mix_sum;

	assign tap1    = p_direct_s2[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
	assign tap2    = p_second_s2[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
	assign tap3    = p_third_s2[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
	assign mix_sum = SUM_W'(x_s2) + SUM_W'(tap1) + SUM_W'(tap2) + SUM_W'(tap3);

	// write port: input and the first two taps go back into the ring
	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			mem_direct[pos_s2] <= x_s2;
			mem_second[pos_s2] <= tap1;
			mem_third[pos_s2]  <= tap2;
		end
	end

	// output register
	logic    out_valid_q;
	sample_t sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2)
			sample_out_q <= mix_sum[MIX_SHIFT+SAMPLE_W-1:MIX_SHIFT];
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

[hdl/cedc_checker.sv]
// Port-level checker for the echo delay core, with its bind.
`include "cascaded_echo_delay_core_defines.svh"

module cedc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input cedc_pkg::sample_t sample_out
);
	// a stalled item holds its value
	`CEDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out), "output item changed while stalled")

	// input is taken exactly when the output side can move
	`CEDC_ASSERT_NOW(a_ready_link, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

	// an accepted item reaches the output if the pipeline does not stall after its accept
	`CEDC_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 in_ready ##1 in_ready, out_valid, "item did not reach output after three cycles")

endmodule

bind cascaded_echo_delay_core cedc_checker u_cedc_checker (.*);

[test/testbench.sv]
// Self-checking testbench for the cascaded three-tap echo delay core.
`timescale 1ns / 100ps

module testbench;
	import cedc_pkg::*;

	localparam int RING_DEPTH  = 24000;
	localparam int DIRECTED_N  = 20;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		sample_t x;
		logic    known;
		sample_t want;
	} row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	setting_t             cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	sample_t              sample_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	sample_t              sample_out;

	// expectation typed into the directed table, carried alongside the item
	logic    row_known = 1'b0;
	sample_t row_want  = '0;

	// predictor state
	sample_t     dry_line   [RING_DEPTH];
	sample_t     echo1_line [RING_DEPTH];
	sample_t     echo2_line [RING_DEPTH];
	int unsigned ring_ptr;
	setting_t    gain_code;
	setting_t    delay_code;

	sample_t     mixed_due [$];
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;

	// sender pacing
	bit          gaps_on     = 1'b1;
	int unsigned burst_left  = 0;
	int unsigned quiet_left  = 0;

	// receiver pacing; hold_req is bumped by the stimulus to ask for a long hold-off
	int unsigned hold_req    = 0;
	int unsigned hold_seen   = 0;
	int unsigned hold_left   = 0;
	int unsigned pat_left    = 0;
	logic [3:0]  pat_pos     = '0;
	logic [15:0] ready_pat   = '1;

	// straight after reset all taps read zero, so the output is the input over four
	row_t directed_rows [DIRECTED_N] = '{
		'{16'sd32767,  1'b1, 16'sd8191},
		'{16'sh8000,   1'b1, -16'sd8192},
		'{16'sd0,      1'b1, 16'sd0},
		'{-16'sd1,     1'b1, -16'sd1},
		'{16'sd1,      1'b1, 16'sd0},
		'{16'sd2,      1'b1, 16'sd0},
		'{16'sd3,      1'b1, 16'sd0},
		'{16'sd4,      1'b1, 16'sd1},
		'{-16'sd2,     1'b1, -16'sd1},
		'{-16'sd3,     1'b1, -16'sd1},
		'{-16'sd4,     1'b1, -16'sd1},
		'{-16'sd5,     1'b1, -16'sd2},
		'{16'sh5555,   1'b1, 16'sd5461},
		'{16'shAAAA,   1'b1, -16'sd5462},
		'{16'sh7FFC,   1'b1, 16'sd8191},
		'{16'sh8003,   1'b1, -16'sd8192},
		'{16'sd256,    1'b1, 16'sd64},
		'{-16'sd256,   1'b1, -16'sd64},
		'{16'sd255,    1'b1, 16'sd63},
		'{-16'sd255,   1'b1, -16'sd64}
	};

	cascaded_echo_delay_core #(
		.MAX_DELAY(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mix one sample against the three rings, then write back and advance
	function automatic sample_t echo_mix(input sample_t x);
		longint      gain_q, t1, t2, t3, acc;
		int unsigned ring_len, pos;
		gain_q   = longint'(gain_code) << GAIN_SHIFT;
		ring_len = BASE_LEN + LEN_STEP * delay_code;
		if (ring_len > RING_DEPTH)
			ring_len = RING_DEPTH;
		pos = ring_ptr;
		if (pos >= RING_DEPTH)
			pos = 0;
		t1  = (longint'(dry_line[pos]) * gain_q) >>> Q_SHIFT;
		t2  = (longint'(echo1_line[pos]) * gain_q) >>> Q_SHIFT;
		t3  = (longint'(echo2_line[pos]) * gain_q) >>> Q_SHIFT;
		acc = longint'(x) + t1 + t2 + t3;
		dry_line[pos]   = x;
		echo1_line[pos] = sample_t'(t1);
		echo2_line[pos] = sample_t'(t2);
		// a shortened ring still uses the stale position once, then wraps
		ring_ptr = (pos + 1 < ring_len) ? ((pos + 1) & 32'h7FFF) : 0;
		return sample_t'(acc >>> MIX_SHIFT);
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return sample_t'($urandom_range(0, 16)) - 16'sd8;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offer one item and hold it until accepted; called on a rising edge
	task automatic feed_sample(input sample_t s, input logic known, input sample_t want);
		if (quiet_left != 0) begin
			quiet_left--;
		end else if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				in_valid <= 1'b0;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(13, 40)) @(posedge clk);
				else
					repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left--;
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		row_known <= known;
		row_want  <= want;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Stop offering and wait until every item has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (mixed_due.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input setting_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_GAIN:  gain_code  = val;
			REG_DELAY: delay_code = val;
			default: ;
		endcase
	endtask

	task automatic run_phase(input setting_t gain, input setting_t delay, input int unsigned n,
			input bit gaps, input bit with_hold);
		drain();
		write_setting(REG_GAIN, gain);
		write_setting(REG_DELAY, delay);
		gaps_on = gaps;
		for (int unsigned k = 0; k < n; k++) begin
			// long receiver hold-off while the sender keeps pushing
			if (with_hold && k == n / 2) begin
				hold_req  <= hold_req + 1;
				quiet_left = 400;
			end
			feed_sample(pick_sample(), 1'b0, '0);
		end
	endtask

	// Stimulus
	initial begin : stimulus
		foreach (dry_line[i]) begin
			dry_line[i]   = '0;
			echo1_line[i] = '0;
			echo2_line[i] = '0;
		end
		ring_ptr   = 0;
		gain_code  = GAIN_RST;
		delay_code = DELAY_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_rows[r])
			feed_sample(directed_rows[r].x, directed_rows[r].known, directed_rows[r].want);

		// shortest ring at full gain, with a long receiver hold-off
		run_phase(8'd255, 8'd0, 500, 1'b1, 1'b1);
		// zero gain, no sender gaps
		run_phase(8'd0, 8'd60, 150, 1'b0, 1'b0);
		// mid gain on a longer ring
		run_phase(8'd128, 8'd100, 400, 1'b1, 1'b0);
		// shorten the ring again, with a second hold-off
		run_phase(8'd200, 8'd0, 150, 1'b1, 1'b1);
		// longest ring, smallest non-zero gain
		run_phase(8'd1, 8'd255, 180, 1'b1, 1'b0);
		run_phase(8'd254, 8'd254, 150, 1'b0, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Output pacing: random stall patterns, plus the requested long hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = 48;
				case ($urandom_range(0, 3))
					0: ready_pat = '1;
					1: ready_pat = 16'($urandom);
					default: ready_pat = 16'($urandom | $urandom);
				endcase
			end
			pat_left--;
			out_ready <= ready_pat[pat_pos];
			pat_pos++;
		end
	end

	// Check returned items, predict accepted ones, and watch for a hang
	always @(posedge clk) begin : monitor
		sample_t want;
		if (out_valid && out_ready) begin
			if (mixed_due.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual sample_out %0d",
					$time, sample_out);
				mismatch_cnt++;
			end else begin
				want = mixed_due.pop_front();
				if (sample_out !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
						$time, want, sample_out);
					mismatch_cnt++;
				end
			end
		end
		// prediction after the check, so an item cannot meet its own result
		if (in_valid && in_ready) begin
			want = echo_mix(sample_in);
			if (row_known)
				want = row_want;
			mixed_due.push_back(want);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
